FILE: src/flsa_pkg.sv
// flsa_pkg: shared constants and codes for the free-list slot allocator.
// No dependencies; imported by flsa_mem, free_list_slot_allocator and tb.
package flsa_pkg;

  localparam int DEPTH_DEF        = 256;
  localparam int PAYLOAD_BITS_DEF = 32;
  localparam int SLOT_FIELD_W     = 9;
  // occupied bit + next-free link + payload at the default sizes
  localparam int ENTRY_W_DEF      = 1 + SLOT_FIELD_W + PAYLOAD_BITS_DEF;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_READ  = 2'd2,
    OP_WRITE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_SLOT = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

endpackage

FILE: src/free_list_slot_allocator.sv
// Free-list slot allocator: at the accepting edge the entry of a valid slot (or the
// free-list head entry, when an allocate pops it) is read from the slot memory; busy is
// then high in the execute cycle, in which the entry is modified and, where the command
// changes it, written back; the result beat appears on the cycle after that with
// out_valid high for one cycle, and a new start is already taken in that same cycle.
// No new command is taken while busy is high. Results cannot be held off. No clearing
// pass after reset: entries are written before they are reachable.
module free_list_slot_allocator
  import flsa_pkg::*;
#(
  parameter int DEPTH        = DEPTH_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              in_opcode,
  input  logic [SLOT_FIELD_W-1:0] in_slot,
  input  logic [PAYLOAD_BITS-1:0] in_payload,
  output logic                    out_valid,
  output logic [1:0]              out_status,
  output logic [SLOT_FIELD_W-1:0] out_granted_slot,
  output logic [PAYLOAD_BITS-1:0] out_read_payload,
  output logic                    out_slot_occupied
);

  localparam int SW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = (SW > SLOT_FIELD_W) ? SW : SLOT_FIELD_W;
  localparam int EW = 1 + SW + PAYLOAD_BITS;
  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t                  state_r, state_nxt;
  op_t                     op_r, op_nxt;
  logic [SW-1:0]           slot_r, slot_nxt;
  logic [PAYLOAD_BITS-1:0] payload_r, payload_nxt;
  logic                    ok_r, ok_nxt;
  logic                    list_r, list_nxt;
  logic [SW-1:0]           head_r, head_nxt;
  logic [SW-1:0]           count_r, count_nxt;

  logic                    out_valid_r, out_valid_nxt;
  status_t                 out_status_r, out_status_nxt;
  logic [SLOT_FIELD_W-1:0] out_granted_r, out_granted_nxt;
  logic [PAYLOAD_BITS-1:0] out_rdata_r, out_rdata_nxt;
  logic                    out_occ_r, out_occ_nxt;

  logic                    mem_we, mem_re;
  logic [AW-1:0]           mem_waddr, mem_raddr;
  logic [EW-1:0]           mem_wdata, mem_rdata;

  logic [CW-1:0]           in_slot_ext, count_ext, slot_r_ext;
  logic                    in_ok;
  logic [SW-1:0]           slot_nxt_m1, slot_r_m1;
  logic                    rd_occ;
  logic [SW-1:0]           rd_next;
  logic [PAYLOAD_BITS-1:0] rd_pl;

  assign in_slot_ext = CW'(in_slot);
  assign count_ext   = CW'(count_r);
  assign slot_r_ext  = CW'(slot_r);
  assign in_ok       = (in_slot_ext != '0) && (in_slot_ext <= count_ext);
  assign slot_nxt_m1 = slot_nxt - SW'(1);
  assign slot_r_m1   = slot_r - SW'(1);

  assign rd_occ  = mem_rdata[EW-1];
  assign rd_next = mem_rdata[PAYLOAD_BITS +: SW];
  assign rd_pl   = mem_rdata[PAYLOAD_BITS-1:0];

  assign mem_raddr = slot_nxt_m1[AW-1:0];
  assign mem_waddr = slot_r_m1[AW-1:0];

  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    slot_nxt        = slot_r;
    payload_nxt     = payload_r;
    ok_nxt          = ok_r;
    list_nxt        = list_r;
    head_nxt        = head_r;
    count_nxt       = count_r;
    out_valid_nxt   = 1'b0;
    out_status_nxt  = out_status_r;
    out_granted_nxt = out_granted_r;
    out_rdata_nxt   = out_rdata_r;
    out_occ_nxt     = out_occ_r;
    mem_re          = 1'b0;
    mem_we          = 1'b0;
    mem_wdata       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt   = S_EXEC;
          op_nxt      = op_t'(in_opcode);
          payload_nxt = in_payload;
          if (op_t'(in_opcode) == OP_ALLOC) begin
            // pop the free list when it holds a slot, else create one past the mark
            list_nxt = (head_r != '0);
            ok_nxt   = (head_r != '0) || (count_r < DEPTH_S);
            slot_nxt = (head_r != '0) ? head_r : count_r + SW'(1);
            mem_re   = (head_r != '0);
          end else begin
            list_nxt = 1'b0;
            ok_nxt   = in_ok;
            slot_nxt = in_slot_ext[SW-1:0];
            mem_re   = in_ok;
          end
        end
      end
      S_EXEC: begin
        state_nxt       = S_IDLE;
        out_valid_nxt   = 1'b1;
        out_status_nxt  = ST_OK;
        out_granted_nxt = '0;
        out_rdata_nxt   = '0;
        out_occ_nxt     = 1'b0;
        case (op_r)
          OP_ALLOC: begin
            if (ok_r) begin
              mem_we          = 1'b1;
              mem_wdata       = {1'b1, SW'(0), payload_r};
              out_granted_nxt = slot_r_ext[SLOT_FIELD_W-1:0];
              if (list_r) begin
                head_nxt = rd_next;
              end else begin
                count_nxt = slot_r;
              end
            end else begin
              out_status_nxt = ST_FULL;
            end
          end
          OP_FREE: begin
            if (!ok_r) begin
              out_status_nxt = ST_BAD_SLOT;
            end else if (rd_occ) begin
              // push onto the free list, keep the payload
              mem_we    = 1'b1;
              mem_wdata = {1'b0, head_r, rd_pl};
              head_nxt  = slot_r;
            end
          end
          OP_READ: begin
            if (!ok_r) begin
              out_status_nxt = ST_BAD_SLOT;
            end else begin
              out_rdata_nxt = rd_pl;
              out_occ_nxt   = rd_occ;
            end
          end
          OP_WRITE: begin
            if (!ok_r) begin
              out_status_nxt = ST_BAD_SLOT;
            end else begin
              mem_we    = 1'b1;
              mem_wdata = {rd_occ, rd_next, payload_r};
            end
          end
          default: begin
            out_status_nxt = ST_BAD_SLOT;
          end
        endcase
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    slot_r        <= slot_nxt;
    payload_r     <= payload_nxt;
    ok_r          <= ok_nxt;
    list_r        <= list_nxt;
    out_status_r  <= out_status_nxt;
    out_granted_r <= out_granted_nxt;
    out_rdata_r   <= out_rdata_nxt;
    out_occ_r     <= out_occ_nxt;
  end

  flsa_mem #(
    .DEPTH   (DEPTH),
    .ENTRY_W (EW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign busy              = (state_r == S_EXEC);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_granted_slot  = out_granted_r;
  assign out_read_payload  = out_rdata_r;
  assign out_slot_occupied = out_occ_r;

  a_beat_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_EXEC))
    else $error("result beat without a preceding execute cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_S)
    else $error("created count beyond depth");

  a_head_created: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= count_r)
    else $error("free-list head points past created slots");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> (head_r == '0 && count_r == DEPTH_S))
    else $error("full reported while a slot was available");

endmodule

FILE: src/flsa_mem.sv
// flsa_mem: single-port-write, single-port-read slot entry memory with a registered read.
// Depends on flsa_pkg for default sizes.
module flsa_mem
  import flsa_pkg::*;
#(
  parameter int DEPTH   = DEPTH_DEF,
  parameter int ENTRY_W = ENTRY_W_DEF
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [ENTRY_W-1:0]         wdata,
  input  logic                       re,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [ENTRY_W-1:0]         rdata
);

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: tb/sv/tb.sv
// tb: self-checking testbench for free_list_slot_allocator (command/strobe interface).
// Predicts every reply from a mirror of the free list and slot store; needs flsa_pkg
// and the allocator RTL only.
module tb;
  import flsa_pkg::*;

  localparam int SLOTS    = DEPTH_DEF;
  localparam int PW       = PAYLOAD_BITS_DEF;
  localparam int SW       = SLOT_FIELD_W;
  localparam int STALL_LIMIT = 5000;

  typedef struct packed {
    status_t         status;
    logic [SW-1:0]   granted;
    logic [PW-1:0]   rdata;
    logic            occupied;
  } slot_reply_t;

  logic          clk   = 1'b0;
  logic          rst_n = 1'b0;
  logic          start = 1'b0;
  logic [1:0]    in_opcode  = '0;
  logic [SW-1:0] in_slot    = '0;
  logic [PW-1:0] in_payload = '0;
  logic          busy;
  logic          out_valid;
  logic [1:0]    out_status;
  logic [SW-1:0] out_granted_slot;
  logic [PW-1:0] out_read_payload;
  logic          out_slot_occupied;

  // mirror of the allocator state
  int            head_slot;
  int            high_water;
  logic          slot_taken [1:SLOTS];
  int            slot_link  [1:SLOTS];
  logic [PW-1:0] slot_data  [1:SLOTS];

  slot_reply_t   pending_replies[$];
  slot_reply_t   want;
  int            mismatches;
  int            quiet_cycles;
  bit            no_idle;

  free_list_slot_allocator dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_opcode         (in_opcode),
    .in_slot           (in_slot),
    .in_payload        (in_payload),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_granted_slot  (out_granted_slot),
    .out_read_payload  (out_read_payload),
    .out_slot_occupied (out_slot_occupied)
  );

  always #4 clk = ~clk;

  function automatic slot_reply_t predict_reply(op_t op, logic [SW-1:0] slot,
                                                logic [PW-1:0] pl);
    slot_reply_t r;
    int g;
    r = '{status: ST_OK, granted: '0, rdata: '0, occupied: 1'b0};
    g = 0;
    if (op == OP_ALLOC) begin
      if (head_slot != 0) begin
        g = head_slot;
        head_slot = slot_link[g];
      end else if (high_water < SLOTS) begin
        high_water++;
        g = high_water;
      end else begin
        r.status = ST_FULL;
      end
      if (g != 0) begin
        slot_data[g]  = pl;
        slot_taken[g] = 1'b1;
        slot_link[g]  = 0;
        r.granted     = SW'(g);
      end
    end else if (slot == 0 || int'(slot) > high_water) begin
      r.status = ST_BAD_SLOT;
    end else if (op == OP_FREE) begin
      // freeing an already free slot leaves the list alone
      if (slot_taken[slot]) begin
        slot_taken[slot] = 1'b0;
        slot_link[slot]  = head_slot;
        head_slot        = int'(slot);
      end
    end else if (op == OP_READ) begin
      r.rdata    = slot_data[slot];
      r.occupied = slot_taken[slot];
    end else begin
      slot_data[slot] = pl;
    end
    return r;
  endfunction

  function automatic void flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
  endfunction

  // Check the reply beat first, then record the command beat taken at this edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (pending_replies.size() == 0) begin
          flag_mismatch("reply beat with no command waiting");
        end else begin
          want = pending_replies.pop_front();
          if (out_status !== want.status)
            flag_mismatch($sformatf("status exp %0d got %0d", want.status, out_status));
          if (out_granted_slot !== want.granted)
            flag_mismatch($sformatf("granted_slot exp %0d got %0d",
                                    want.granted, out_granted_slot));
          if (out_read_payload !== want.rdata)
            flag_mismatch($sformatf("read_payload exp %08h got %08h",
                                    want.rdata, out_read_payload));
          if (out_slot_occupied !== want.occupied)
            flag_mismatch($sformatf("slot_occupied exp %0b got %0b",
                                    want.occupied, out_slot_occupied));
        end
      end
      if (start && !busy)
        pending_replies.push_back(predict_reply(op_t'(in_opcode), in_slot, in_payload));
      if (out_valid || (start && !busy)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  // Hold the command until taken, then idle now and then.
  task automatic send_cmd(input op_t op, input logic [SW-1:0] slot, input logic [PW-1:0] pl);
    start      <= 1'b1;
    in_opcode  <= op;
    in_slot    <= slot;
    in_payload <= pl;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (!no_idle && $urandom_range(99) < 27) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  task automatic drain_replies();
    start <= 1'b0;
    @(posedge clk);
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  function automatic logic [PW-1:0] pick_payload();
    int r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    return PW'($urandom());
  endfunction

  function automatic logic [SW-1:0] pick_slot();
    int r;
    r = $urandom_range(99);
    if (r < 82 && high_water > 0) return SW'($urandom_range(high_water, 1));
    if (r < 88) return '0;
    return SW'($urandom_range(511, 0));
  endfunction

  task automatic rand_cmds(input int count, input int alloc_w, input int free_w,
                           input int read_w);
    int r;
    op_t op;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < alloc_w) op = OP_ALLOC;
      else if (r < alloc_w + free_w) op = OP_FREE;
      else if (r < alloc_w + free_w + read_w) op = OP_READ;
      else op = OP_WRITE;
      send_cmd(op, pick_slot(), pick_payload());
    end
  endtask

  task automatic test_directed();
    send_cmd(OP_READ,  9'd0,   '0);            // slot zero is invalid
    send_cmd(OP_READ,  9'd1,   '0);            // nothing created yet
    send_cmd(OP_FREE,  9'd1,   '0);
    send_cmd(OP_WRITE, 9'd1,   '1);
    send_cmd(OP_ALLOC, 9'd0,   '0);
    send_cmd(OP_ALLOC, 9'd511, '1);
    send_cmd(OP_READ,  9'd1,   '0);
    send_cmd(OP_READ,  9'd2,   '0);
    send_cmd(OP_WRITE, 9'd2,   32'hA5A5_A5A5);
    send_cmd(OP_READ,  9'd2,   '0);
    send_cmd(OP_FREE,  9'd1,   '0);
    send_cmd(OP_FREE,  9'd1,   '0);            // already free
    send_cmd(OP_READ,  9'd1,   '0);            // payload kept, not occupied
    send_cmd(OP_WRITE, 9'd1,   32'h5A5A_5A5A); // write while free
    send_cmd(OP_READ,  9'd1,   '0);
    send_cmd(OP_ALLOC, 9'd0,   32'h1234_5678); // reuses slot 1
    send_cmd(OP_FREE,  9'd2,   '0);
    send_cmd(OP_FREE,  9'd1,   '0);
    send_cmd(OP_ALLOC, 9'd0,   32'h0000_0001); // last freed comes back first
    send_cmd(OP_ALLOC, 9'd0,   32'h8000_0000);
    send_cmd(OP_READ,  9'd3,   '0);            // beyond created slots
    send_cmd(OP_READ,  9'd511, '0);
    send_cmd(OP_FREE,  9'd256, '0);
    send_cmd(OP_WRITE, 9'd300, '1);
  endtask

  task automatic test_growth();
    rand_cmds(450, 38, 20, 22);
  endtask

  task automatic test_fill_to_full();
    // enough allocates to empty the free list and reach the top, then overflow
    for (int i = 0; i < 258; i++) send_cmd(OP_ALLOC, pick_slot(), pick_payload());
    send_cmd(OP_READ,  9'd256, '0);
    send_cmd(OP_WRITE, 9'd256, '1);
    send_cmd(OP_FREE,  9'd256, '0);
    send_cmd(OP_READ,  9'd256, '0);
    send_cmd(OP_READ,  9'd257, '0);
    send_cmd(OP_FREE,  9'd511, '0);
    drain_replies();
  endtask

  task automatic test_burst_no_idle();
    no_idle = 1'b1;
    rand_cmds(200, 30, 25, 25);
    no_idle = 1'b0;
  endtask

  task automatic test_churn();
    rand_cmds(500, 30, 30, 22);
  endtask

  initial begin
    head_slot  = 0;
    high_water = 0;
    mismatches = 0;
    quiet_cycles = 0;
    no_idle    = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_growth();
    test_fill_to_full();
    test_burst_no_idle();
    test_churn();
    drain_replies();
    repeat (6) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/flsa_pkg.sv
src/flsa_mem.sv
src/free_list_slot_allocator.sv
tb/sv/tb.sv
